// File: hdl/tva_pkg.sv
// shared types and constants for the tagged value alu
// no dependencies; imported by every module of the block
`default_nettype none

package tva_pkg;

  localparam int unsigned MODE_W = 4;
  localparam int unsigned TAG_W  = 2;

  // operand and result type tags
  localparam logic [TAG_W-1:0] TAG_NUM  = 2'd0;
  localparam logic [TAG_W-1:0] TAG_BOOL = 2'd1;
  localparam logic [TAG_W-1:0] TAG_ERR  = 2'd2;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_IF  = 4'd0,
    MODE_OR  = 4'd1,
    MODE_AND = 4'd2,
    MODE_EQ  = 4'd3,
    MODE_LT  = 4'd4,
    MODE_ADD = 4'd5,
    MODE_SUB = 4'd6,
    MODE_MUL = 4'd7,
    MODE_DIV = 4'd8,
    MODE_REM = 4'd9,
    MODE_NOT = 4'd10,
    MODE_NEG = 4'd11
  } mode_e;

  // control that rides along with each word through the pipeline
  typedef struct packed {
    logic [TAG_W-1:0] tag;     // final result tag
    logic             div_op;  // result is the floored quotient
    logic             rem_op;  // result is the floored modulo
    logic             na;      // dividend negative
    logic             nb;      // divisor negative
  } ctrl_t;

endpackage : tva_pkg

`default_nettype wire

// File: hdl/tva_pre.sv
// front stage: type check, all non-divide operations including multiply, divider setup
// depends on tva_pkg
`default_nettype none

module tva_pre #(
  parameter int unsigned W = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [tva_pkg::MODE_W-1:0] mode_i,
  input  wire logic [tva_pkg::TAG_W-1:0]  a_tag_i,
  input  wire logic [W-1:0]             a_value_i,
  input  wire logic [tva_pkg::TAG_W-1:0]  b_tag_i,
  input  wire logic [W-1:0]             b_value_i,
  input  wire logic [tva_pkg::TAG_W-1:0]  c_tag_i,
  input  wire logic [W-1:0]             c_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output tva_pkg::ctrl_t                out_ctrl_o,
  output logic [W-1:0]                  out_val_o,
  output logic [W-1:0]                  out_dvs_o,
  output logic [W-1:0]                  out_rem_o,
  output logic [W-1:0]                  out_dq_o
);
  import tva_pkg::*;

  logic         valid_q;
  ctrl_t        ctrl_d, ctrl_q;
  logic [W-1:0] val_d, val_q;
  logic [W-1:0] ma_d, ma_q;
  logic [W-1:0] mb_d, mb_q;
  logic         nums, bools;
  logic [W-1:0] prod;
  logic [W-1:0] one_w;

  assign one_w = {{(W-1){1'b0}}, 1'b1};
  assign nums  = (a_tag_i == TAG_NUM) && (b_tag_i == TAG_NUM);
  assign bools = (a_tag_i == TAG_BOOL) && (b_tag_i == TAG_BOOL);
  assign prod  = a_value_i * b_value_i;

  // decode and evaluate
  always_comb begin
    ctrl_d     = '0;
    ctrl_d.tag = TAG_ERR;
    val_d      = '0;
    ctrl_d.na  = a_value_i[W-1];
    ctrl_d.nb  = b_value_i[W-1];
    ma_d       = a_value_i[W-1] ? (~a_value_i + one_w) : a_value_i;
    mb_d       = b_value_i[W-1] ? (~b_value_i + one_w) : b_value_i;
    unique case (mode_i)
      MODE_IF: begin
        if (c_tag_i == TAG_BOOL) begin
          if (c_value_i == one_w) begin
            ctrl_d.tag = a_tag_i;
            val_d      = a_value_i;
          end else begin
            ctrl_d.tag = b_tag_i;
            val_d      = b_value_i;
          end
        end
      end
      MODE_OR: begin
        if (bools) begin
          ctrl_d.tag = TAG_BOOL;
          val_d      = ((a_value_i != '0) || (b_value_i != '0)) ? one_w : '0;
        end
      end
      MODE_AND: begin
        if (bools) begin
          ctrl_d.tag = TAG_BOOL;
          val_d      = ((a_value_i != '0) && (b_value_i != '0)) ? one_w : '0;
        end
      end
      MODE_EQ: begin
        if (nums) begin
          ctrl_d.tag = TAG_BOOL;
          val_d      = (a_value_i == b_value_i) ? one_w : '0;
        end
      end
      MODE_LT: begin
        if (nums) begin
          ctrl_d.tag = TAG_BOOL;
          val_d      = ($signed(a_value_i) < $signed(b_value_i)) ? one_w : '0;
        end
      end
      MODE_ADD: begin
        if (nums) begin
          ctrl_d.tag = TAG_NUM;
          val_d      = a_value_i + b_value_i;
        end
      end
      MODE_SUB: begin
        if (nums) begin
          ctrl_d.tag = TAG_NUM;
          val_d      = a_value_i - b_value_i;
        end
      end
      MODE_MUL: begin
        if (nums) begin
          ctrl_d.tag = TAG_NUM;
          val_d      = prod;
        end
      end
      MODE_DIV: begin
        if (nums && (b_value_i != '0)) begin
          ctrl_d.tag    = TAG_NUM;
          ctrl_d.div_op = 1'b1;
        end
      end
      MODE_REM: begin
        if (nums && (b_value_i != '0)) begin
          ctrl_d.tag    = TAG_NUM;
          ctrl_d.rem_op = 1'b1;
        end
      end
      MODE_NOT: begin
        if (a_tag_i == TAG_BOOL) begin
          ctrl_d.tag = TAG_BOOL;
          val_d      = (a_value_i == '0) ? one_w : '0;
        end
      end
      MODE_NEG: begin
        if (a_tag_i == TAG_NUM) begin
          ctrl_d.tag = TAG_NUM;
          val_d      = '0 - a_value_i;
        end
      end
      default: begin
        ctrl_d.tag = TAG_ERR;
      end
    endcase
    // error results carry a zero value
    if (ctrl_d.tag == TAG_ERR) begin
      val_d = '0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctrl_q <= ctrl_d;
      val_q  <= val_d;
      ma_q   <= ma_d;
      mb_q   <= mb_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_val_o   = val_q;
  assign out_dvs_o   = mb_q;
  assign out_rem_o   = '0;
  assign out_dq_o    = ma_q;

endmodule : tva_pre

`default_nettype wire

// File: hdl/tva_div_cell.sv
// one cell of the divider chain: one restoring step, one quotient bit
// depends on tva_pkg
`default_nettype none

module tva_div_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire tva_pkg::ctrl_t in_ctrl_i,
  input  wire logic [W-1:0]   in_val_i,
  input  wire logic [W-1:0]   in_dvs_i,
  input  wire logic [W-1:0]   in_rem_i,
  input  wire logic [W-1:0]   in_dq_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tva_pkg::ctrl_t      out_ctrl_o,
  output logic [W-1:0]        out_val_o,
  output logic [W-1:0]        out_dvs_o,
  output logic [W-1:0]        out_rem_o,
  output logic [W-1:0]        out_dq_o
);
  import tva_pkg::*;

  logic         valid_q;
  ctrl_t        ctrl_q;
  logic [W-1:0] val_q, dvs_q;
  logic [W-1:0] rem_d, rem_q;
  logic [W-1:0] dq_d, dq_q;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         qbit;

  // shift in the next dividend bit and try the subtract
  assign trial = {in_rem_i, in_dq_i[W-1]};
  assign diff  = trial - {1'b0, in_dvs_i};
  assign qbit  = !diff[W];
  assign rem_d = qbit ? diff[W-1:0] : trial[W-1:0];
  assign dq_d  = {in_dq_i[W-2:0], qbit};

  assign in_ready_o = !valid_q || out_ready_i;

  // cell valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // cell payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctrl_q <= in_ctrl_i;
      val_q  <= in_val_i;
      dvs_q  <= in_dvs_i;
      rem_q  <= rem_d;
      dq_q   <= dq_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_val_o   = val_q;
  assign out_dvs_o   = dvs_q;
  assign out_rem_o   = rem_q;
  assign out_dq_o    = dq_q;

endmodule : tva_div_cell

`default_nettype wire

// File: hdl/tva_post.sv
// back stage: floored sign fix of quotient and modulo, output register
// depends on tva_pkg
`default_nettype none

module tva_post #(
  parameter int unsigned W = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tva_pkg::ctrl_t            in_ctrl_i,
  input  wire logic [W-1:0]              in_val_i,
  input  wire logic [W-1:0]              in_dvs_i,
  input  wire logic [W-1:0]              in_rem_i,
  input  wire logic [W-1:0]              in_dq_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [tva_pkg::TAG_W-1:0]      out_tag_o,
  output logic [W-1:0]                   out_value_o
);
  import tva_pkg::*;

  logic             valid_q;
  logic [TAG_W-1:0] tag_q;
  logic [W-1:0]     value_d, value_q;
  logic [W-1:0]     quo, modv;
  logic             rm_nz, differ;

  assign rm_nz  = (in_rem_i != '0);
  assign differ = in_ctrl_i.na ^ in_ctrl_i.nb;

  // floored quotient: -(q+1) is ~q
  always_comb begin
    if (!differ) begin
      quo = in_dq_i;
    end else if (rm_nz) begin
      quo = ~in_dq_i;
    end else begin
      quo = '0 - in_dq_i;
    end
  end

  // floored modulo takes the sign of the divisor
  always_comb begin
    if (!differ) begin
      modv = in_ctrl_i.na ? ('0 - in_rem_i) : in_rem_i;
    end else if (!rm_nz) begin
      modv = '0;
    end else if (in_ctrl_i.nb) begin
      modv = in_rem_i - in_dvs_i;
    end else begin
      modv = in_dvs_i - in_rem_i;
    end
  end

  // result select
  always_comb begin
    if (in_ctrl_i.div_op) begin
      value_d = quo;
    end else if (in_ctrl_i.rem_op) begin
      value_d = modv;
    end else begin
      value_d = in_val_i;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tag_q   <= in_ctrl_i.tag;
      value_q <= value_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tag_o   = tag_q;
  assign out_value_o = value_q;

endmodule : tva_post

`default_nettype wire

// File: hdl/tagged_value_alu_top.sv
// top level of the tagged value alu: front stage, divider cell chain, back stage
// depends on tva_pkg, tva_pre, tva_div_cell, tva_post
//
//   channel   dir  handshake                    word
//   s_axis    in   s_axis_tvalid/s_axis_tready  opcode and three tagged operands
//   m_axis    out  m_axis_tvalid/m_axis_tready  tagged result
//
// one word per cycle sustained while the output is not stalled; each word is registered in
// the front stage, each restoring divider cell (one quotient bit per cell) and the back stage
// every operation takes the same path, so results leave in input order
// each stage holds its word while the next one is full; a stalled output
// register stalls only the stages behind it that are full
// reset clears the stage valid bits only; no memory to sweep
`default_nettype none

module tagged_value_alu_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // mode[3:0], a_tag[1:0], a_value, b_tag[1:0], b_value, c_tag[1:0], c_value, zero pad
  input  wire logic [((10 + 3 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // result_tag[1:0], result_value, zero pad
  output logic [((2 + VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import tva_pkg::*;

  localparam int unsigned W       = VALUE_WIDTH;
  localparam int unsigned OUT_W   = ((2 + W + 7) / 8) * 8;
  localparam int unsigned A_TAG_L = MODE_W;
  localparam int unsigned A_VAL_L = A_TAG_L + TAG_W;
  localparam int unsigned B_TAG_L = A_VAL_L + W;
  localparam int unsigned B_VAL_L = B_TAG_L + TAG_W;
  localparam int unsigned C_TAG_L = B_VAL_L + W;
  localparam int unsigned C_VAL_L = C_TAG_L + TAG_W;
  localparam int unsigned PAD_OUT = OUT_W - TAG_W - W;

  // links between stages: index 0 leaves the front stage, index W enters the back
  logic         lk_valid [W+1];
  logic         lk_ready [W+1];
  ctrl_t        lk_ctrl  [W+1];
  logic [W-1:0] lk_val   [W+1];
  logic [W-1:0] lk_dvs   [W+1];
  logic [W-1:0] lk_rem   [W+1];
  logic [W-1:0] lk_dq    [W+1];

  logic [TAG_W-1:0] res_tag;
  logic [W-1:0]     res_value;

  // front stage
  tva_pre #(.W(W)) u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tdata[MODE_W-1:0]),
    .a_tag_i     (s_axis_tdata[A_TAG_L +: TAG_W]),
    .a_value_i   (s_axis_tdata[A_VAL_L +: W]),
    .b_tag_i     (s_axis_tdata[B_TAG_L +: TAG_W]),
    .b_value_i   (s_axis_tdata[B_VAL_L +: W]),
    .c_tag_i     (s_axis_tdata[C_TAG_L +: TAG_W]),
    .c_value_i   (s_axis_tdata[C_VAL_L +: W]),
    .out_valid_o (lk_valid[0]),
    .out_ready_i (lk_ready[0]),
    .out_ctrl_o  (lk_ctrl[0]),
    .out_val_o   (lk_val[0]),
    .out_dvs_o   (lk_dvs[0]),
    .out_rem_o   (lk_rem[0]),
    .out_dq_o    (lk_dq[0])
  );

  // divider cell chain
  for (genvar gi = 0; gi < W; gi++) begin : g_cell
    tva_div_cell #(.W(W)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (lk_valid[gi]),
      .in_ready_o  (lk_ready[gi]),
      .in_ctrl_i   (lk_ctrl[gi]),
      .in_val_i    (lk_val[gi]),
      .in_dvs_i    (lk_dvs[gi]),
      .in_rem_i    (lk_rem[gi]),
      .in_dq_i     (lk_dq[gi]),
      .out_valid_o (lk_valid[gi+1]),
      .out_ready_i (lk_ready[gi+1]),
      .out_ctrl_o  (lk_ctrl[gi+1]),
      .out_val_o   (lk_val[gi+1]),
      .out_dvs_o   (lk_dvs[gi+1]),
      .out_rem_o   (lk_rem[gi+1]),
      .out_dq_o    (lk_dq[gi+1])
    );
  end

  // back stage and output register
  tva_post #(.W(W)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lk_valid[W]),
    .in_ready_o  (lk_ready[W]),
    .in_ctrl_i   (lk_ctrl[W]),
    .in_val_i    (lk_val[W]),
    .in_dvs_i    (lk_dvs[W]),
    .in_rem_i    (lk_rem[W]),
    .in_dq_i     (lk_dq[W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tag_o   (res_tag),
    .out_value_o (res_value)
  );

  assign m_axis_tdata = {{PAD_OUT{1'b0}}, res_value, res_tag};

  // error results always carry a zero value
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_tag == TAG_ERR) |-> (res_value == '0))
    else $error("error result with nonzero value");

  // input back-pressure only ever comes from a held result
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held result");

  // an accepted word sits in the front stage on the next cycle
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tready && !m_axis_tvalid
    |-> ##1 lk_valid[0])
    else $error("front stage lost an accepted word");

endmodule : tagged_value_alu_top

`default_nettype wire
